>>> sv/hash_group_aggregate_unit_macros.svh
// Assertion macros for the hash group aggregation unit.
// Used by the top level; needs a signal named clk and one named rst in scope.
`ifndef HASH_GROUP_AGGREGATE_UNIT_MACROS_SVH
`define HASH_GROUP_AGGREGATE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HGA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define HGA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HGA_ASSERT_SAME(lbl, ante, cons, msg)
`define HGA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/hga_pkg.sv
// Shared constants, codes, state types and records of the group aggregation unit.
// No dependencies.
package hga_pkg;
  localparam int MAX_GROUPS  = 512;
  localparam int TABLE_SLOTS = 1024;
  localparam int KEY_FIELDS  = 4;
  localparam int GRP_W   = $clog2(MAX_GROUPS);
  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int GCNT_W  = $clog2(MAX_GROUPS + 1);
  localparam int PROBE_W = $clog2(TABLE_SLOTS + 1);
  localparam int KC_W    = $clog2(KEY_FIELDS + 1);
  localparam int KI_W    = (KEY_FIELDS > 1) ? $clog2(KEY_FIELDS) : 1;
  localparam int NK_W    = 3;

  localparam logic [63:0] MIX_C1     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2     = 64'h94d049bb133111eb;
  localparam logic [63:0] FNV_OFFSET = 64'd1469598103934665603;
  localparam logic [63:0] FNV_PRIME  = 64'd1099511628211;
  localparam int SH_A = 30;
  localparam int SH_B = 27;
  localparam int SH_C = 31;

  typedef enum logic [1:0] {OP_ACC = 2'd0, OP_READ = 2'd1, OP_CLEAR = 2'd2, OP_NONE = 2'd3}
    opcode_t;
  typedef enum logic [1:0] {ST_OK = 2'd0, ST_FULL = 2'd1, ST_UNUSED = 2'd2} status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_SREAD, S_SCHK, S_GUPD, S_RREQ, S_RDATA, S_EMIT
  } hga_state_t;

  typedef enum logic [2:0] {HP_IDLE, HP_LOAD, HP_M1, HP_M2, HP_FNV, HP_DONE} hash_phase_t;

  typedef struct packed {
    logic              used;
    logic [63:0]       hash;
    logic [GRP_W-1:0]  grp;
  } slot_entry_t;

  typedef struct packed {
    logic [31:0] count;
    logic [63:0] sum;
    logic [63:0] min;
    logic [63:0] max;
    logic [31:0] first;
  } grp_entry_t;

  typedef struct packed {
    logic              done;
    logic [63:0]       hash;
    logic [SLOT_W-1:0] slot;
  } hash_res_t;

  typedef struct packed {
    logic [GRP_W-1:0] group_index;
    logic             is_new;
    logic [1:0]       status;
    logic [31:0]      row_count;
    logic [63:0]      sum_value;
    logic [63:0]      min_value;
    logic [63:0]      max_value;
    logic [31:0]      first_row;
  } result_t;
endpackage

>>> sv/hga_row_if.sv
// Input channel carrying one row item with valid and ready.
// Depends on hga_pkg.
interface hga_row_if import hga_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [63:0] key_0;
  logic signed [63:0] key_1;
  logic signed [63:0] key_2;
  logic signed [63:0] key_3;
  logic signed [63:0] agg_value;
  logic [GRP_W-1:0]   group_select;
  modport source (output valid, opcode, key_0, key_1, key_2, key_3, agg_value, group_select,
                  input ready);
  modport sink (input valid, opcode, key_0, key_1, key_2, key_3, agg_value, group_select,
                output ready);
endinterface

>>> sv/hga_res_if.sv
// Output channel carrying one result item with valid and ready.
// Depends on hga_pkg.
interface hga_res_if import hga_pkg::*;;
  logic               valid;
  logic               ready;
  logic [GRP_W-1:0]   group_index;
  logic               is_new;
  logic [1:0]         status;
  logic [31:0]        row_count;
  logic signed [63:0] sum_value;
  logic signed [63:0] min_value;
  logic signed [63:0] max_value;
  logic [31:0]        first_row;
  modport source (output valid, group_index, is_new, status, row_count, sum_value, min_value,
                  max_value, first_row, input ready);
  modport sink (input valid, group_index, is_new, status, row_count, sum_value, min_value,
                max_value, first_row, output ready);
endinterface

>>> sv/hash_group_aggregate_unit.sv
// Group-by aggregation unit: rows are hashed on up to four keys and their value is
// accumulated into a group found by linear probing. Items are taken one at a time. A taken
// row is hashed on the shared 32x32 multiplier, each probe of the slot memory passes
// through a read state and a check state, a group read-modify-write follows when the row
// joins an existing group, and an emit state hands over the result. A read of a used
// group passes through a request and a data state before its emit state; any other item
// goes straight to emit. One result register sits on the output; an item waits in its
// emit state while the previous result is still held there. After reset and after each
// clear item all 1024 slots of the slot memory are swept, one slot a cycle, while no item
// is taken. Depends on hga_pkg, the channel interfaces, hga_ram and hga_hash.
`include "hash_group_aggregate_unit_macros.svh"
module hash_group_aggregate_unit import hga_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [NK_W-1:0] cfg_wdata,
  hga_row_if.sink         rows,
  hga_res_if.source       results
);
  hga_state_t state, state_next;
  logic [NK_W-1:0]  num_keys;
  logic [GCNT_W-1:0] groups_in_use;
  logic [31:0]      row_counter, row_q;
  logic [KEY_FIELDS-1:0][63:0] keys_q;
  logic [63:0]      val_q;
  logic [GRP_W-1:0] sel_q, grp_q;
  logic [SLOT_W-1:0] pos, clr_cnt;
  logic [PROBE_W-1:0] probes;
  logic             clr_pend;
  result_t          res;
  logic             out_valid;
  result_t          out_q;

  logic             accept, hstart, out_free;
  logic [KC_W-1:0]  nk;
  hash_res_t        hres;
  logic             s_we, g_we;
  logic [SLOT_W-1:0] s_waddr, s_raddr;
  logic [GRP_W-1:0] g_waddr, g_raddr;
  slot_entry_t      s_wdata, s_rd;
  grp_entry_t       g_wdata, g_rd, g_upd;
  logic [$bits(slot_entry_t)-1:0] s_rdata;
  logic [$bits(grp_entry_t)-1:0]  g_rdata;
  logic             hit, full_new, probe_end;

  assign s_rd     = slot_entry_t'(s_rdata);
  assign g_rd     = grp_entry_t'(g_rdata);
  assign accept   = rows.valid && rows.ready;
  assign out_free = !out_valid || results.ready;
  assign nk       = (num_keys > NK_W'(KEY_FIELDS)) ? KC_W'(KEY_FIELDS) : KC_W'(num_keys);
  assign hit       = s_rd.used && (s_rd.hash == hres.hash);
  assign full_new  = groups_in_use >= GCNT_W'(MAX_GROUPS);
  assign probe_end = (probes + 1'b1) == PROBE_W'(TABLE_SLOTS);

  hga_ram #(.WIDTH($bits(slot_entry_t)), .DEPTH(TABLE_SLOTS)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr),
    .rdata(s_rdata));

  hga_ram #(.WIDTH($bits(grp_entry_t)), .DEPTH(MAX_GROUPS)) u_grp_ram (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(g_raddr),
    .rdata(g_rdata));

  hga_hash u_hash (
    .clk(clk), .rst(rst), .start(hstart), .keys(keys_q), .nk(nk), .res(hres));

  always_comb begin
    g_upd.count = (g_rd.count != '1) ? g_rd.count + 32'd1 : g_rd.count;
    g_upd.sum   = g_rd.sum + val_q;
    g_upd.min   = ($signed(val_q) < $signed(g_rd.min)) ? val_q : g_rd.min;
    g_upd.max   = ($signed(g_rd.max) < $signed(val_q)) ? val_q : g_rd.max;
    g_upd.first = g_rd.first;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == SLOT_W'(TABLE_SLOTS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (opcode_t'(rows.opcode))
            OP_ACC:  state_next = S_HASH;
            OP_READ: state_next = (GCNT_W'(rows.group_select) < groups_in_use) ? S_RREQ
                                                                               : S_EMIT;
            OP_CLEAR: state_next = S_EMIT;
            OP_NONE:  state_next = S_EMIT;
          endcase
        end
      end
      S_HASH:  if (hres.done) state_next = S_SREAD;
      S_SREAD: state_next = S_SCHK;
      S_SCHK: begin
        if (!s_rd.used) state_next = S_EMIT;
        else if (hit) state_next = S_GUPD;
        else state_next = probe_end ? S_EMIT : S_SREAD;
      end
      S_GUPD:  state_next = S_EMIT;
      S_RREQ:  state_next = S_RDATA;
      S_RDATA: state_next = S_EMIT;
      S_EMIT:  if (out_free) state_next = clr_pend ? S_CLEAR : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rows.ready = (state == S_IDLE);
    hstart     = (state == S_IDLE) && accept && (opcode_t'(rows.opcode) == OP_ACC);
    s_we       = (state == S_CLEAR) || ((state == S_SCHK) && !s_rd.used && !full_new);
    s_waddr    = (state == S_CLEAR) ? clr_cnt : pos;
    s_wdata.used = (state != S_CLEAR);
    s_wdata.hash = hres.hash;
    s_wdata.grp  = groups_in_use[GRP_W-1:0];
    s_raddr    = pos;
    g_raddr    = (state == S_SCHK) ? s_rd.grp : sel_q;
    g_we       = ((state == S_SCHK) && !s_rd.used && !full_new) || (state == S_GUPD);
    g_waddr    = (state == S_GUPD) ? grp_q : groups_in_use[GRP_W-1:0];
    if (state == S_GUPD) begin
      g_wdata = g_upd;
    end else begin
      g_wdata.count = 32'd1;
      g_wdata.sum   = val_q;
      g_wdata.min   = val_q;
      g_wdata.max   = val_q;
      g_wdata.first = row_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      num_keys      <= NK_W'(1);
      groups_in_use <= '0;
      row_counter   <= '0;
      clr_cnt       <= '0;
      clr_pend      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        num_keys <= cfg_wdata;
      end
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
        clr_pend  <= 1'b0;
        clr_cnt   <= '0;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (accept && opcode_t'(rows.opcode) == OP_ACC) begin
        row_counter <= row_counter + 32'd1;
      end
      if (accept && opcode_t'(rows.opcode) == OP_CLEAR) begin
        row_counter   <= '0;
        groups_in_use <= '0;
        clr_pend      <= 1'b1;
      end
      if (state == S_SCHK && !s_rd.used && !full_new) begin
        groups_in_use <= groups_in_use + 1'b1;
      end
    end

    if (state == S_EMIT && out_free) begin
      out_q <= res;
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          keys_q[0] <= rows.key_0;
          keys_q[1] <= rows.key_1;
          keys_q[2] <= rows.key_2;
          keys_q[3] <= rows.key_3;
          val_q     <= rows.agg_value;
          sel_q     <= rows.group_select;
          row_q     <= row_counter;
          if (opcode_t'(rows.opcode) == OP_READ) begin
            res <= '{group_index: rows.group_select, status: ST_UNUSED, default: '0};
          end else begin
            res <= '0;
          end
        end
      end
      S_HASH: begin
        pos    <= hres.slot;
        probes <= '0;
      end
      S_SCHK: begin
        grp_q  <= s_rd.grp;
        pos    <= pos + 1'b1;
        probes <= probes + 1'b1;
        if (!s_rd.used) begin
          if (full_new) begin
            res.status <= ST_FULL;
          end else begin
            res.group_index <= groups_in_use[GRP_W-1:0];
            res.is_new      <= 1'b1;
            res.status      <= ST_OK;
            res.row_count   <= 32'd1;
            res.sum_value   <= val_q;
            res.min_value   <= val_q;
            res.max_value   <= val_q;
            res.first_row   <= row_q;
          end
        end else if (!hit && probe_end) begin
          res.status <= ST_FULL;
        end
      end
      S_GUPD: begin
        res.group_index <= grp_q;
        res.status      <= ST_OK;
        res.row_count   <= g_upd.count;
        res.sum_value   <= g_upd.sum;
        res.min_value   <= g_upd.min;
        res.max_value   <= g_upd.max;
        res.first_row   <= g_upd.first;
      end
      S_RDATA: begin
        res.group_index <= sel_q;
        res.status      <= ST_OK;
        res.row_count   <= g_rd.count;
        res.sum_value   <= g_rd.sum;
        res.min_value   <= g_rd.min;
        res.max_value   <= g_rd.max;
        res.first_row   <= g_rd.first;
      end
      default: ;
    endcase
  end

  assign results.valid       = out_valid;
  assign results.group_index = out_q.group_index;
  assign results.is_new      = out_q.is_new;
  assign results.status      = out_q.status;
  assign results.row_count   = out_q.row_count;
  assign results.sum_value   = out_q.sum_value;
  assign results.min_value   = out_q.min_value;
  assign results.max_value   = out_q.max_value;
  assign results.first_row   = out_q.first_row;

  `HGA_ASSERT_SAME(a_groups_bound, 1'b1, groups_in_use <= GCNT_W'(MAX_GROUPS), "group overflow")
  `HGA_ASSERT_SAME(a_no_take_in_clear, state == S_CLEAR, !rows.ready, "item taken in clear")
  `HGA_ASSERT_NEXT(a_row_starts_hash, accept && rows.opcode == OP_ACC, state == S_HASH, "no hash")
endmodule

>>> sv/hga_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/hga_hash.sv
// Key folding and slot hash unit built around one shared 32x32 multiplier.
// Depends on hga_pkg.
module hga_hash import hga_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [KEY_FIELDS-1:0][63:0]    keys,
  input  logic [KC_W-1:0]                nk,
  output hash_res_t                      res
);
  hash_phase_t phase, phase_next;
  logic [63:0] x, h, acc;
  logic [1:0]  step;
  logic [KC_W-1:0] kcnt;
  logic        fin;
  logic [SLOT_W-1:0] slot;
  logic [63:0] ma, mb, sum, ym, yf, kv;
  logic [31:0] pa, pb;
  logic [63:0] prod;
  logic        last;

  // A 64-bit product modulo 2^64 takes three partial products.
  always_comb begin
    ma = (phase == HP_FNV) ? h : x;
    unique case (phase)
      HP_M1:   mb = MIX_C1;
      HP_M2:   mb = MIX_C2;
      HP_FNV:  mb = FNV_PRIME;
      default: mb = '0;
    endcase
    unique case (step)
      2'd1:    begin pa = ma[31:0];  pb = mb[63:32]; end
      2'd2:    begin pa = ma[63:32]; pb = mb[31:0];  end
      default: begin pa = ma[31:0];  pb = mb[31:0];  end
    endcase
    prod = 64'(pa) * 64'(pb);
    sum  = (step == 2'd0) ? prod : acc + {prod[31:0], 32'd0};
    last = (step == 2'd2);
    ym   = sum ^ (sum >> SH_B);
    yf   = sum ^ (sum >> SH_C);
    kv   = keys[kcnt[KI_W-1:0]];
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      HP_IDLE: if (start) phase_next = HP_LOAD;
      HP_LOAD: phase_next = HP_M1;
      HP_M1:   if (last) phase_next = HP_M2;
      HP_M2:   if (last) phase_next = fin ? HP_DONE : HP_FNV;
      HP_FNV:  if (last) phase_next = HP_LOAD;
      HP_DONE: phase_next = HP_IDLE;
      default: phase_next = HP_IDLE;
    endcase
  end

  always_comb begin
    res.done = (phase == HP_DONE);
    res.hash = h;
    res.slot = slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= HP_IDLE;
      step  <= 2'd0;
    end else begin
      phase <= phase_next;
      if (phase == HP_M1 || phase == HP_M2 || phase == HP_FNV) begin
        step <= last ? 2'd0 : step + 2'd1;
      end else begin
        step <= 2'd0;
      end
    end
    acc <= sum;
    unique case (phase)
      HP_IDLE: begin
        if (start) begin
          h    <= FNV_OFFSET;
          kcnt <= '0;
        end
      end
      HP_LOAD: begin
        if (kcnt < nk) begin
          x   <= kv ^ (kv >> SH_A);
          fin <= 1'b0;
        end else begin
          x   <= h ^ (h >> SH_A);
          fin <= 1'b1;
        end
      end
      HP_M1: if (last) x <= ym;
      HP_M2: begin
        if (last) begin
          if (fin) begin
            slot <= yf[SLOT_W-1:0];
          end else begin
            h <= h ^ yf;
          end
        end
      end
      HP_FNV: begin
        if (last) begin
          h    <= sum;
          kcnt <= kcnt + 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule
